[sv/distinct_count_point_update_top_macros.svh]
// Assertion macros shared by the distinct count point update RTL.
`ifndef DISTINCT_COUNT_POINT_UPDATE_TOP_MACROS_SVH
`define DISTINCT_COUNT_POINT_UPDATE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge of clk, skipped while rst is high.
`define DCPU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check a property on every rising edge of clk, reset included.
`define DCPU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define DCPU_ASSERT(label, clk, rst, prop)
`define DCPU_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[sv/dcpu_pkg.sv]
// Shared constants, types and helper functions of the distinct count block.
package dcpu_pkg;

  localparam int NUM_ENTRIES = 1024;
  localparam int VALUE_BITS  = 16;

  localparam int POS_W    = 10;
  localparam int NEWVAL_W = 16;
  localparam int OUT_W    = 11;
  localparam int CNT_W    = 11;
  localparam int EXT_W    = 24;
  localparam int POS_EXT_W = 17;

  localparam int ENT_AW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int HIST_DEPTH = 1 << VALUE_BITS;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2047);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_INC_WR
  } state_t;

  typedef struct packed {
    logic capture;      // latch the input word
    logic ent_wr;       // write the new value into the entry store
    logic hist_rd_old;  // read the bin of the old entry value
    logic hist_rd_new;  // read the bin of the new value
    logic dec_wr;       // write back the decremented old bin
    logic inc_wr;       // write back the incremented new bin
    logic clr_wr;       // clear one histogram bin
    logic emit_now;     // report the count without touching the store
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic clr_last;
  } stat_t;

  function automatic logic [VALUE_BITS-1:0] val_of(input logic [NEWVAL_W-1:0] v);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(v);
    return ext[VALUE_BITS-1:0];
  endfunction

  function automatic logic [ENT_AW-1:0] ent_addr(input logic [POS_W-1:0] p);
    logic [POS_EXT_W-1:0] ext;
    ext = POS_EXT_W'(p);
    return ext[ENT_AW-1:0];
  endfunction

  function automatic logic pos_in_range(input logic [POS_W-1:0] p);
    return POS_EXT_W'(p) < POS_EXT_W'(NUM_ENTRIES);
  endfunction

endpackage

[sv/dcpu_ram.sv]
// Generic simple dual port RAM with one write port and a registered read port.
module dcpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when it hits the address being written.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[sv/dcpu_ctrl.sv]
// Sequencer that steps the histogram read-modify-write cycles.
`include "distinct_count_point_update_top_macros.svh"

module dcpu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           req_type,
  input  dcpu_pkg::stat_t stat,
  output logic           busy,
  output dcpu_pkg::cmd_t cmd
);
  import dcpu_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && stat.in_range) begin
          state_next = (req_type == REQ_UPDATE) ? ST_DEC_RD : ST_INC_WR;
        end
      end
      ST_DEC_RD: state_next = ST_DEC_WR;
      ST_DEC_WR: state_next = ST_INC_WR;
      ST_INC_WR: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = accept;
        if (accept && stat.in_range && (req_type == REQ_LOAD)) begin
          cmd.ent_wr      = 1'b1;
          cmd.hist_rd_new = 1'b1;
        end
        cmd.emit_now = accept && !stat.in_range && (req_type == REQ_UPDATE);
      end
      ST_DEC_RD: begin
        cmd.hist_rd_old = 1'b1;
        cmd.ent_wr      = 1'b1;
      end
      ST_DEC_WR: begin
        cmd.dec_wr      = 1'b1;
        cmd.hist_rd_new = 1'b1;
      end
      ST_INC_WR: cmd.inc_wr = 1'b1;
      default: cmd = '0;
    endcase
  end

  `DCPU_ASSERT(a_one_hist_write, clk, rst, $onehot0({cmd.clr_wr, cmd.dec_wr, cmd.inc_wr}))
  `DCPU_ASSERT(a_update_walks, clk, rst, accept && stat.in_range && (req_type == REQ_UPDATE) |=> state == ST_DEC_RD)
  `DCPU_ASSERT(a_busy_during_clear, clk, rst, state == ST_CLEAR |-> busy && !cmd.capture)

endmodule

[sv/dcpu_dpath.sv]
// Entry store, histogram memory, bin arithmetic and result register.
`include "distinct_count_point_update_top_macros.svh"

module dcpu_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  dcpu_pkg::cmd_t                  cmd,
  output dcpu_pkg::stat_t                 stat,
  input  logic                            req_type,
  input  logic [dcpu_pkg::POS_W-1:0]      position,
  input  logic [dcpu_pkg::NEWVAL_W-1:0]   new_value,
  output logic [dcpu_pkg::OUT_W-1:0]      distinct_plus_one,
  output logic                            done
);
  import dcpu_pkg::*;

  logic [POS_W-1:0]      pos_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] old_q;
  logic                  upd_q;
  logic                  same_q;
  logic [CNT_W-1:0]      dec_q;
  logic [CNT_W-1:0]      live_cnt, live_cnt_next;
  logic [VALUE_BITS-1:0] clr_cnt;

  logic [VALUE_BITS-1:0] in_val;
  logic [VALUE_BITS-1:0] ent_rdata;
  logic [ENT_AW-1:0]     ent_waddr;
  logic [VALUE_BITS-1:0] ent_wdata;

  logic [VALUE_BITS-1:0] hist_raddr, hist_waddr;
  logic [CNT_W-1:0]      hist_rdata, hist_wdata;
  logic                  hist_we;

  logic [CNT_W-1:0]      cur_cnt, dec_cnt, inc_cnt;
  logic [CNT_W:0]        res_sum;
  logic                  emit;

  assign in_val        = val_of(new_value);
  assign stat.in_range = pos_in_range(position);
  assign stat.clr_last = &clr_cnt;

  assign ent_waddr = ent_addr(cmd.capture ? position : pos_q);
  assign ent_wdata = cmd.capture ? in_val : val_q;

  dcpu_ram #(.WIDTH(VALUE_BITS), .DEPTH(NUM_ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (cmd.ent_wr),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_addr(position)),
    .rdata (ent_rdata)
  );

  assign hist_raddr = cmd.hist_rd_old ? ent_rdata : (cmd.capture ? in_val : val_q);
  assign hist_we    = cmd.clr_wr || cmd.dec_wr || cmd.inc_wr;
  assign hist_waddr = cmd.clr_wr ? clr_cnt : (cmd.dec_wr ? old_q : val_q);
  assign hist_wdata = cmd.clr_wr ? '0 : (cmd.dec_wr ? dec_cnt : inc_cnt);

  dcpu_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Forward the decremented bin when old and new value share it.
  assign cur_cnt = (cmd.inc_wr && same_q) ? dec_q : hist_rdata;
  assign dec_cnt = (cur_cnt == '0) ? cur_cnt : cur_cnt - CNT_W'(1);
  assign inc_cnt = (cur_cnt >= CNT_MAX) ? cur_cnt : cur_cnt + CNT_W'(1);

  always_comb begin
    live_cnt_next = live_cnt;
    if (cmd.dec_wr && (cur_cnt == CNT_W'(1)) && (live_cnt != '0)) begin
      live_cnt_next = live_cnt - CNT_W'(1);
    end
    if (cmd.inc_wr && (cur_cnt == '0) && (live_cnt != CNT_MAX)) begin
      live_cnt_next = live_cnt + CNT_W'(1);
    end
  end

  assign res_sum = {1'b0, live_cnt_next} + (CNT_W + 1)'(1);
  assign emit    = (cmd.inc_wr && upd_q) || cmd.emit_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_cnt <= '0;
      clr_cnt  <= '0;
      done     <= 1'b0;
    end else begin
      live_cnt <= live_cnt_next;
      done     <= emit;
      if (cmd.clr_wr) clr_cnt <= clr_cnt + VALUE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_q  <= position;
      val_q  <= in_val;
      upd_q  <= req_type;
      same_q <= 1'b0;
    end
    if (cmd.hist_rd_old) old_q <= ent_rdata;
    if (cmd.dec_wr) begin
      dec_q  <= dec_cnt;
      same_q <= (val_q == old_q);
    end
    if (emit) begin
      distinct_plus_one <= res_sum[CNT_W] ? CNT_MAX : res_sum[CNT_W-1:0];
    end
  end

  `DCPU_ASSERT(a_inc_after_read, clk, rst, cmd.inc_wr |-> $past(cmd.hist_rd_new))
  `DCPU_ASSERT(a_result_nonzero, clk, rst, done |-> distinct_plus_one != '0)

endmodule

[sv/distinct_count_point_update_top.sv]
// Top level of the distinct count block with point updates.
//
// Keeps a store of entry values and a histogram with one bin per value, and
// reports the number of distinct stored values plus one after each update.
// A word is taken at a rising edge where start is high and busy is low. A load
// word (req_type 0) writes the entry and reads the new bin, then writes the
// new bin, and gives no result; an update word (req_type 1) with an in-range
// position runs these steps: entry read, old bin read, old bin write with new
// bin read, new bin write. These steps are set by the single write port and
// registered read of the histogram memory. An update with a position beyond
// the store keeps busy low and only reports the count. The result word shows on
// distinct_plus_one with done high for exactly one cycle, in the cycle after
// the last step; it must be taken then, since the receiver cannot hold it off.
// After reset the block clears the histogram, one bin a cycle, and holds busy
// high until all 2^VALUE_BITS bins (65536 here) are clear. A new data set needs
// a reset. Reading an entry that was never loaded gives an undefined result.
module distinct_count_point_update_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [dcpu_pkg::POS_W-1:0]    position,
  input  logic [dcpu_pkg::NEWVAL_W-1:0] new_value,
  output logic [dcpu_pkg::OUT_W-1:0]    distinct_plus_one,
  output logic                          done
);
  import dcpu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence the read-modify-write steps; hold busy while clearing.
  dcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Store entries, update bins and the running count, register the result.
  dcpu_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .req_type          (req_type),
    .position          (position),
    .new_value         (new_value),
    .distinct_plus_one (distinct_plus_one),
    .done              (done)
  );

endmodule

[test/dcpu_checker.sv]
// Checker that predicts the distinct-value count and compares each result word.
module dcpu_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          req_type,
  input  logic [dcpu_pkg::POS_W-1:0]    position,
  input  logic [dcpu_pkg::NEWVAL_W-1:0] new_value,
  input  logic [dcpu_pkg::OUT_W-1:0]    distinct_plus_one,
  input  logic                          done,
  output int                            fail_count,
  output int                            pending_results,
  output int                            results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import dcpu_pkg::*;

  logic [VALUE_BITS-1:0] entry_store [NUM_ENTRIES];
  logic [CNT_W-1:0]      bin_tally [HIST_DEPTH];
  logic [CNT_W-1:0]      live_values;
  logic [OUT_W-1:0]      expected_counts [$];
  logic [OUT_W-1:0]      want;
  int                    mismatches = 0;
  int                    checked = 0;

  task automatic report_mismatch(input string what);
    $display("dcpu_checker: mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // A full bin ignores further increments; the live count saturates too.
  task automatic bump_bin(input logic [VALUE_BITS-1:0] v);
    if (bin_tally[v] == CNT_MAX) return;
    if (bin_tally[v] == '0 && live_values != CNT_MAX) live_values++;
    bin_tally[v] = bin_tally[v] + 1'b1;
  endtask

  // An empty bin stays empty and leaves the live count alone.
  task automatic drop_bin(input logic [VALUE_BITS-1:0] v);
    if (bin_tally[v] == '0) return;
    bin_tally[v] = bin_tally[v] - 1'b1;
    if (bin_tally[v] == '0 && live_values != '0) live_values--;
  endtask

  function automatic logic [OUT_W-1:0] count_word();
    logic [CNT_W:0] sum;
    sum = {1'b0, live_values} + 1'b1;
    if (sum > {1'b0, CNT_MAX}) sum = {1'b0, CNT_MAX};
    return sum[OUT_W-1:0];
  endfunction

  task automatic take_word(input logic rt, input logic [POS_W-1:0] pos,
                           input logic [NEWVAL_W-1:0] val);
    logic [VALUE_BITS-1:0] v;
    logic                  hit;
    v   = val[VALUE_BITS-1:0];
    hit = int'(pos) < NUM_ENTRIES;
    if (rt == REQ_LOAD) begin
      if (hit) begin
        entry_store[pos] = v;
        bump_bin(v);
      end
    end else begin
      if (hit) begin
        drop_bin(entry_store[pos]);
        entry_store[pos] = v;
        bump_bin(v);
      end
      expected_counts = {expected_counts, count_word()};
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) bin_tally[i] = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) entry_store[i] = '0;
      live_values = '0;
      expected_counts.delete();
    end else begin
      // retire a result before taking a new word in the same cycle
      if (done === 1'b1) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with no update waiting", distinct_plus_one));
        end else begin
          want = expected_counts.pop_front();
          checked++;
          if (distinct_plus_one !== want)
            report_mismatch($sformatf("distinct_plus_one %0d, expected %0d",
                                      distinct_plus_one, want));
        end
      end
      if (start === 1'b1 && busy === 1'b0) take_word(req_type, position, new_value);
    end
    fail_count      <= mismatches;
    pending_results <= expected_counts.size();
    results_checked <= checked;
  end

endmodule

[test/tb_top.sv]
// Testbench top: drives load and update words into the distinct count block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dcpu_pkg::*;

  // The limit allows for the histogram clear after reset and for the rest
  // of the run, about 1800 words with their idle gaps.
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int RANDOM_WORDS = 1200;
  localparam int SAT_WORDS    = 250;
  localparam int LATE_UPDATES = 100;
  localparam int DRAIN_CYCLES = 16;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                req_type = REQ_LOAD;
  logic [POS_W-1:0]    position = '0;
  logic [NEWVAL_W-1:0] new_value = '0;
  logic                busy;
  logic [OUT_W-1:0]    distinct_plus_one;
  logic                done;

  int fail_count;
  int pending_results;
  int results_checked;

  int cycle_count = 0;
  int loads_sent = 0;
  int updates_sent = 0;
  bit quiet_run = 1'b0;

  // Positions that hold a loaded value; only these may be updated, since an
  // update of a never-loaded entry reads undefined data.
  bit written_mask [NUM_ENTRIES];
  int written_list [$];

  always #6 clk = ~clk;

  distinct_count_point_update_top dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .req_type          (req_type),
    .position          (position),
    .new_value         (new_value),
    .distinct_plus_one (distinct_plus_one),
    .done              (done)
  );

  dcpu_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .req_type          (req_type),
    .position          (position),
    .new_value         (new_value),
    .distinct_plus_one (distinct_plus_one),
    .done              (done),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .results_checked   (results_checked)
  );

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Idle gap before a word: mostly none or short, now and then long, and
  // none at all while a quiet run is in force.
  function automatic int idle_cycles();
    int roll;
    if (quiet_run) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Pick gapped or back-to-back pace anew every 64 words.
  task automatic maybe_switch_pace(input int idx);
    if (idx % 64 == 0) quiet_run = ($urandom_range(0, 3) == 0);
  endtask

  // Present one word and hold it until the block takes it (start high and
  // busy low at a rising edge). Start drops only when a gap follows, so it
  // never gets two assignments in one step.
  task automatic send_word(input logic rt, input logic [POS_W-1:0] pos,
                           input logic [NEWVAL_W-1:0] val);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    req_type  <= rt;
    position  <= pos;
    new_value <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (rt == REQ_LOAD) begin
      loads_sent++;
      if (!written_mask[pos]) begin
        written_mask[pos] = 1'b1;
        written_list = {written_list, int'(pos)};
      end
    end else begin
      updates_sent++;
    end
  endtask

  function automatic logic [POS_W-1:0] pick_written();
    return POS_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
  endfunction

  // Load positions: often near the ends so that repeated loads happen.
  function automatic logic [POS_W-1:0] pick_load_pos();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return POS_W'($urandom_range(0, 15));
    if (roll < 3) return POS_W'($urandom_range(NUM_ENTRIES - 16, NUM_ENTRIES - 1));
    return POS_W'($urandom);
  endfunction

  // Values: a small pool so bins fill and empty, the extremes, or anything.
  function automatic logic [NEWVAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return NEWVAL_W'(16'h0F00 + $urandom_range(0, 11));
    if (roll < 7) return ($urandom_range(0, 1) == 1) ? '1 : '0;
    return NEWVAL_W'($urandom);
  endfunction

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) written_mask[i] = 1'b0;

    // Hold reset, then release; the block clears its histogram while busy.
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: extreme positions and values, a value whose bin
    // empties, an update to the same value, and a repeated load.
    send_word(REQ_LOAD,   10'd0,    16'h0000);
    send_word(REQ_LOAD,   10'd1023, 16'hFFFF);
    send_word(REQ_LOAD,   10'd1,    16'h0000);
    send_word(REQ_UPDATE, 10'd0,    16'hFFFF);
    send_word(REQ_UPDATE, 10'd1,    16'h5555);
    send_word(REQ_UPDATE, 10'd1,    16'h5555);
    send_word(REQ_UPDATE, 10'd1023, 16'hAAAA);
    send_word(REQ_LOAD,   10'd0,    16'h5555);
    send_word(REQ_UPDATE, 10'd0,    16'h0000);
    send_word(REQ_LOAD,   10'd512,  16'h0001);
    send_word(REQ_UPDATE, 10'd512,  16'h8000);
    send_word(REQ_UPDATE, 10'd512,  16'h7FFF);
    send_word(REQ_LOAD,   10'h2AA,  16'hFFFE);
    send_word(REQ_LOAD,   10'h155,  16'h0001);
    send_word(REQ_UPDATE, 10'h2AA,  16'h0001);
    send_word(REQ_UPDATE, 10'h155,  16'hFFFE);
    send_word(REQ_UPDATE, 10'd1023, 16'hFFFF);
    send_word(REQ_UPDATE, 10'd0,    16'hFFFF);
    send_word(REQ_UPDATE, 10'h2AA,  16'hFFFF);

    // Random mix: load until 32 positions hold values, then mostly updates of
    // loaded positions with loads mixed in, some of them overwrites.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      maybe_switch_pace(i);
      if (written_list.size() < 32 || $urandom_range(0, 3) == 0)
        send_word(REQ_LOAD, pick_load_pos(), pick_value());
      else
        send_word(REQ_UPDATE, pick_written(), pick_value());
    end

    // Pile loads onto one value: loads only add, so its bin grows large.
    for (int i = 0; i < SAT_WORDS; i++) begin
      maybe_switch_pace(i);
      send_word(REQ_LOAD, POS_W'($urandom), 16'h1234);
    end

    // Load many distinct values so the live count climbs.
    for (int i = 0; i < SAT_WORDS; i++) begin
      maybe_switch_pace(i);
      send_word(REQ_LOAD, POS_W'($urandom), NEWVAL_W'(16'h4000 + i));
    end

    // Updates against the crowded state: bins empty and the count drops.
    for (int i = 0; i < LATE_UPDATES; i++) begin
      maybe_switch_pace(i);
      case ($urandom_range(0, 3))
        0: send_word(REQ_UPDATE, pick_written(), 16'h1234);
        1: send_word(REQ_UPDATE, pick_written(),
                     NEWVAL_W'(16'h4000 + $urandom_range(0, SAT_WORDS - 1)));
        default: send_word(REQ_UPDATE, pick_written(), NEWVAL_W'($urandom));
      endcase
    end

    start <= 1'b0;

    // Drain: wait for the last result, then a few more cycles for strays.
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d load words and %0d update words sent, %0d results checked",
             loads_sent, updates_sent, results_checked);
    $display("tb_top: run covered repeated loads, emptied bins, a crowded bin and many values");
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
